### rtl/core/cocktail_shaker_sorter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cocktail shaker sorter core
// Concurrent checks compiled for simulation, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef COCKTAIL_SHAKER_SORTER_CORE_DEFINES_SVH
`define COCKTAIL_SHAKER_SORTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define CSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define CSS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CSS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CSS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/core/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Constants, control word types and the microcode program of the sorter.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int DefMaxElems  = 64;
  localparam int DefValueBits = 32;
  localparam int SwapBits     = 11;
  localparam int StepBits     = 5;

  // datapath operation of one microcode step
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_INIT,
    OP_FSTART,
    OP_READ,
    OP_CMP,
    OP_WRHI,
    OP_INC,
    OP_FEND,
    OP_BSTART,
    OP_DEC,
    OP_BEND,
    OP_ESTART,
    OP_EREAD,
    OP_EOUT,
    OP_CLEAR
  } op_e;

  // jump condition: taken jumps to target, else the step counter advances
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_LOADED_LAST,
    C_SHORT,
    C_NO_RANGE,
    C_NOT_GT,
    C_FWD_MORE,
    C_NOT_SWAPPED,
    C_BWD_MORE,
    C_SWAPPED,
    C_OUT_BUSY,
    C_EMIT_MORE
  } cond_e;

  typedef struct packed {
    op_e                 op;
    cond_e               cond;
    logic [StepBits-1:0] target;
  } uword_t;

  localparam logic [StepBits-1:0] S_LOAD   = 5'd0;
  localparam logic [StepBits-1:0] S_INIT   = 5'd1;
  localparam logic [StepBits-1:0] S_FSTART = 5'd2;
  localparam logic [StepBits-1:0] S_FRD    = 5'd3;
  localparam logic [StepBits-1:0] S_FCMP   = 5'd4;
  localparam logic [StepBits-1:0] S_FWRHI  = 5'd5;
  localparam logic [StepBits-1:0] S_FNEXT  = 5'd6;
  localparam logic [StepBits-1:0] S_FEND   = 5'd7;
  localparam logic [StepBits-1:0] S_BSTART = 5'd8;
  localparam logic [StepBits-1:0] S_BRD    = 5'd9;
  localparam logic [StepBits-1:0] S_BCMP   = 5'd10;
  localparam logic [StepBits-1:0] S_BWRHI  = 5'd11;
  localparam logic [StepBits-1:0] S_BNEXT  = 5'd12;
  localparam logic [StepBits-1:0] S_BEND   = 5'd13;
  localparam logic [StepBits-1:0] S_ESTART = 5'd14;
  localparam logic [StepBits-1:0] S_ERD    = 5'd15;
  localparam logic [StepBits-1:0] S_EOUT   = 5'd16;
  localparam logic [StepBits-1:0] S_ENEXT  = 5'd17;
  localparam logic [StepBits-1:0] S_DONE   = 5'd18;

  // control store
  function automatic uword_t ucode(input logic [StepBits-1:0] step);
    uword_t w;
    case (step)
      S_LOAD:   w = '{OP_LOAD,   C_NOT_LOADED_LAST, S_LOAD};
      S_INIT:   w = '{OP_INIT,   C_SHORT,           S_ESTART};
      S_FSTART: w = '{OP_FSTART, C_NO_RANGE,        S_FEND};
      S_FRD:    w = '{OP_READ,   C_NEVER,           S_LOAD};
      S_FCMP:   w = '{OP_CMP,    C_NOT_GT,          S_FNEXT};
      S_FWRHI:  w = '{OP_WRHI,   C_NEVER,           S_LOAD};
      S_FNEXT:  w = '{OP_INC,    C_FWD_MORE,        S_FRD};
      S_FEND:   w = '{OP_FEND,   C_NOT_SWAPPED,     S_ESTART};
      S_BSTART: w = '{OP_BSTART, C_NO_RANGE,        S_BEND};
      S_BRD:    w = '{OP_READ,   C_NEVER,           S_LOAD};
      S_BCMP:   w = '{OP_CMP,    C_NOT_GT,          S_BNEXT};
      S_BWRHI:  w = '{OP_WRHI,   C_NEVER,           S_LOAD};
      S_BNEXT:  w = '{OP_DEC,    C_BWD_MORE,        S_BRD};
      S_BEND:   w = '{OP_BEND,   C_SWAPPED,         S_FSTART};
      S_ESTART: w = '{OP_ESTART, C_NEVER,           S_LOAD};
      S_ERD:    w = '{OP_EREAD,  C_NEVER,           S_LOAD};
      S_EOUT:   w = '{OP_EOUT,   C_OUT_BUSY,        S_EOUT};
      S_ENEXT:  w = '{OP_INC,    C_EMIT_MORE,       S_ERD};
      S_DONE:   w = '{OP_CLEAR,  C_ALWAYS,          S_LOAD};
      default:  w = '{OP_CLEAR,  C_ALWAYS,          S_LOAD};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/cocktail_shaker_sorter_core.sv
// Loading takes one element per cycle; each compare reads the pair, compares it and, when it swaps,
// writes the lower slot and then the upper slot; each emit step reads an element and waits for the sink.
// The sort time is set by the single-write-port element memory that every compare-and-swap goes through.
// One list is in flight at a time: input is taken only while the sequencer is loading.
// Reset: asynchronous active low; clears the step counter, bounds, counts and output valid.
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter_core
// Loads signed values, sorts them ascending with a cocktail shaker sort run by
// a microcoded sequencer over an element memory, then streams them out.
// ----------------------------------------------------------------------------
`include "cocktail_shaker_sorter_core_defines.svh"

module cocktail_shaker_sorter_core #(
  parameter int MAX_ELEMS  = css_pkg::DefMaxElems,
  parameter int VALUE_BITS = css_pkg::DefValueBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: elem_value
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  input  logic                s_axis_tlast_i,   // elem_last
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata: sorted_value, swap_total
  output logic [((VALUE_BITS + css_pkg::SwapBits + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o    // out_last
);

  localparam int OutBits = ((VALUE_BITS + css_pkg::SwapBits + 7) / 8) * 8;
  localparam int AW      = $clog2(MAX_ELEMS);
  localparam int CW      = $clog2(MAX_ELEMS + 1);
  localparam int SB      = css_pkg::SwapBits;

  // sequencer and control registers
  logic [css_pkg::StepBits-1:0] step_q, step_d;
  logic [CW-1:0]                count_q, count_d;
  logic [AW-1:0]                low_q, low_d;
  logic [AW-1:0]                high_q, high_d;
  logic [AW-1:0]                p_q, p_d;
  logic                         swapped_q, swapped_d;
  logic [SB-1:0]                swaps_q, swaps_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0]        out_value_q, out_value_d;
  logic [SB-1:0]                out_swap_q, out_swap_d;
  logic                         out_last_q, out_last_d;

  // element memory
  logic [VALUE_BITS-1:0]        mem [MAX_ELEMS];
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [VALUE_BITS-1:0]        wr_data;
  logic                         rd_en;
  logic                         rd_pair;
  logic [VALUE_BITS-1:0]        rd_a_q, rd_b_q;

  css_pkg::uword_t              uw;
  logic                         cond_hit;
  logic                         in_xfer;
  logic                         out_free;
  logic                         gt;
  logic [AW-1:0]                p_nxt;
  logic [AW:0]                  p_inc_w;
  logic [CW-1:0]                p_inc_c;
  logic [CW-1:0]                count_m1;
  logic [VALUE_BITS-1:0]        in_value;

  assign uw       = css_pkg::ucode(step_q);
  assign in_value = s_axis_tdata_i[VALUE_BITS-1:0];
  assign s_axis_tready_o = (uw.op == css_pkg::OP_LOAD);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign gt       = $signed(rd_a_q) > $signed(rd_b_q);
  assign p_inc_w  = {1'b0, p_q} + {{AW{1'b0}}, 1'b1};
  assign p_nxt    = p_inc_w[AW-1:0];
  assign p_inc_c  = CW'(p_q) + CW'(1);
  assign count_m1 = count_q - CW'(1);

  always_comb begin
    case (uw.cond)
      css_pkg::C_NEVER:           cond_hit = 1'b0;
      css_pkg::C_ALWAYS:          cond_hit = 1'b1;
      css_pkg::C_NOT_LOADED_LAST: cond_hit = !(in_xfer && s_axis_tlast_i);
      css_pkg::C_SHORT:           cond_hit = count_q < CW'(2);
      css_pkg::C_NO_RANGE:        cond_hit = low_q >= high_q;
      css_pkg::C_NOT_GT:          cond_hit = !gt;
      css_pkg::C_FWD_MORE:        cond_hit = p_inc_w < {1'b0, high_q};
      css_pkg::C_NOT_SWAPPED:     cond_hit = !swapped_q;
      css_pkg::C_BWD_MORE:        cond_hit = p_q > low_q;
      css_pkg::C_SWAPPED:         cond_hit = swapped_q;
      css_pkg::C_OUT_BUSY:        cond_hit = !out_free;
      css_pkg::C_EMIT_MORE:       cond_hit = p_inc_c < count_q;
      default:                    cond_hit = 1'b0;
    endcase
  end

  assign step_d = cond_hit ? uw.target : step_q + css_pkg::StepBits'(1);

  always_comb begin
    count_d     = count_q;
    low_d       = low_q;
    high_d      = high_q;
    p_d         = p_q;
    swapped_d   = swapped_q;
    swaps_d     = swaps_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_value_d = out_value_q;
    out_swap_d  = out_swap_q;
    out_last_d  = out_last_q;
    wr_en       = 1'b0;
    wr_addr     = p_q;
    wr_data     = rd_b_q;
    rd_en       = 1'b0;
    rd_pair     = 1'b0;
    case (uw.op)
      css_pkg::OP_LOAD: begin
        // elements past a full store are dropped
        if (in_xfer && (count_q < CW'(MAX_ELEMS))) begin
          wr_en   = 1'b1;
          wr_addr = count_q[AW-1:0];
          wr_data = in_value;
          count_d = count_q + CW'(1);
        end
      end
      css_pkg::OP_INIT: begin
        low_d  = '0;
        high_d = count_m1[AW-1:0];
      end
      css_pkg::OP_FSTART: begin
        swapped_d = 1'b0;
        p_d       = low_q;
      end
      css_pkg::OP_READ: begin
        rd_en   = 1'b1;
        rd_pair = 1'b1;
      end
      css_pkg::OP_CMP: begin
        // lower slot takes the smaller value, the upper slot follows next step
        if (gt) begin
          wr_en     = 1'b1;
          wr_addr   = p_q;
          wr_data   = rd_b_q;
          swapped_d = 1'b1;
          swaps_d   = swaps_q + SB'(1);
        end
      end
      css_pkg::OP_WRHI: begin
        wr_en   = 1'b1;
        wr_addr = p_nxt;
        wr_data = rd_a_q;
      end
      css_pkg::OP_INC:    p_d = p_nxt;
      css_pkg::OP_DEC:    p_d = p_q - AW'(1);
      css_pkg::OP_FEND:   high_d = high_q - AW'(1);
      css_pkg::OP_BSTART: begin
        swapped_d = 1'b0;
        p_d       = high_q - AW'(1);
      end
      css_pkg::OP_BEND:   low_d = low_q + AW'(1);
      css_pkg::OP_ESTART: p_d = '0;
      css_pkg::OP_EREAD:  rd_en = 1'b1;
      css_pkg::OP_EOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = rd_a_q;
          out_last_d  = (p_inc_c == count_q);
          out_swap_d  = (p_inc_c == count_q) ? swaps_q : '0;
        end
      end
      css_pkg::OP_CLEAR: begin
        count_d   = '0;
        swaps_d   = '0;
        low_d     = '0;
        high_d    = '0;
        swapped_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= css_pkg::S_LOAD;
      count_q     <= '0;
      low_q       <= '0;
      high_q      <= '0;
      p_q         <= '0;
      swapped_q   <= 1'b0;
      swaps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      count_q     <= count_d;
      low_q       <= low_d;
      high_q      <= high_d;
      p_q         <= p_d;
      swapped_q   <= swapped_d;
      swaps_q     <= swaps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_swap_q  <= out_swap_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_a_q <= mem[p_q];
      if (rd_pair) begin
        rd_b_q <= mem[p_nxt];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutBits'({out_swap_q, out_value_q});
  assign m_axis_tlast_o  = out_last_q;

  `CSS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(MAX_ELEMS))
  `CSS_ASSERT_NXT(a_swap_second_half, clk_i, rst_ni,
                  (uw.op == css_pkg::OP_CMP) && gt, (uw.op == css_pkg::OP_WRHI))
  `CSS_ASSERT_IMP(a_pair_in_range, clk_i, rst_ni,
                  (uw.op == css_pkg::OP_READ), (p_q < high_q) && (p_q >= low_q))
  `CSS_ASSERT_IMP(a_total_on_last, clk_i, rst_ni, out_valid_q && !out_last_q, out_swap_q == '0)

endmodule

### verif/cocktail_shaker_sorter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter_core_tb
// Streams lists of signed Q16.16 values into the sorter and checks every
// sorted output transfer, the swap total and the last flag against an
// in-bench cocktail shaker sort. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module cocktail_shaker_sorter_core_tb;

  localparam int ValBits   = css_pkg::DefValueBits;
  localparam int SwpBits   = css_pkg::SwapBits;
  localparam int ListDepth = css_pkg::DefMaxElems;
  localparam int InBits    = ((ValBits + 7) / 8) * 8;
  localparam int OutBits   = ((ValBits + SwpBits + 7) / 8) * 8;

  typedef struct {
    logic [ValBits-1:0] value;
    logic               last;
    bit                 drain;  // hold back until every sorted value is out
  } elem_item_t;

  typedef struct {
    logic [ValBits-1:0] value;
    logic [SwpBits-1:0] swaps;
    logic               last;
  } sorted_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [InBits-1:0]  s_axis_tdata_i = '0;
  logic               s_axis_tlast_i = 1'b0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [OutBits-1:0] m_axis_tdata_o;
  logic               m_axis_tlast_o;

  elem_item_t   elem_q[$];
  sorted_item_t sorted_q[$];

  logic signed [ValBits-1:0] list_buf [ListDepth];
  int list_len  = 0;
  int elems_in  = 0;
  int drained   = 0;
  int mismatches = 0;

  cocktail_shaker_sorter_core #(
    .MAX_ELEMS  (ListDepth),
    .VALUE_BITS (ValBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void add_elem(input logic [ValBits-1:0] v, input logic l, input bit d);
    elem_item_t it;
    it.value = v;
    it.last  = l;
    it.drain = d;
    elem_q.push_back(it);
  endfunction

  function automatic logic [ValBits-1:0] rand_elem();
    case ($urandom_range(5))
      0: return ValBits'($signed($urandom_range(16)) - 8);  // clusters of equal values
      1: begin
        case ($urandom_range(3))
          0:       return {1'b1, {(ValBits-1){1'b0}}};
          1:       return {1'b0, {(ValBits-1){1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // ascending cocktail shaker sort of the list buffer, returns the swap count
  function automatic logic [SwpBits-1:0] shaker_sort();
    logic [SwpBits-1:0]        swaps;
    logic signed [ValBits-1:0] t;
    int lo, hi;
    bit swapped;
    swaps = '0;
    if (list_len < 2) return swaps;
    lo = 0;
    hi = list_len - 1;
    swapped = 1'b1;
    while (swapped) begin
      swapped = 1'b0;
      for (int i = lo; i < hi; i++) begin
        if (list_buf[i] > list_buf[i+1]) begin
          t = list_buf[i]; list_buf[i] = list_buf[i+1]; list_buf[i+1] = t;
          swapped = 1'b1;
          swaps++;
        end
      end
      if (!swapped) break;
      swapped = 1'b0;
      hi--;
      for (int i = hi; i > lo; i--) begin
        if (list_buf[i-1] > list_buf[i]) begin
          t = list_buf[i-1]; list_buf[i-1] = list_buf[i]; list_buf[i] = t;
          swapped = 1'b1;
          swaps++;
        end
      end
      lo++;
    end
    return swaps;
  endfunction

  // store one element; the last one sorts the list and queues the sorted values
  function automatic void accept_elem(input elem_item_t it);
    logic [SwpBits-1:0] swaps;
    sorted_item_t       r;
    if (list_len < ListDepth) begin
      list_buf[list_len] = it.value;
      list_len++;
    end
    if (it.last) begin
      swaps = shaker_sort();
      for (int k = 0; k < list_len; k++) begin
        r.value = list_buf[k];
        r.last  = (k == list_len - 1);
        r.swaps = r.last ? swaps : '0;
        sorted_q.push_back(r);
      end
      list_len = 0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [ValBits-1:0] got,
                                 input logic [ValBits-1:0] want);
    mismatches++;
    $display("%0t: %s: got %h, want %h", $time, what, got, want);
  endtask

  // input side: hold each element until its transfer, then maybe idle
  always @(posedge clk_i or negedge rst_ni) begin
    elem_item_t nxt;
    bit         holding;
    bit         go;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      holding = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        nxt.value = s_axis_tdata_i[ValBits-1:0];
        nxt.last  = s_axis_tlast_i;
        nxt.drain = 1'b0;
        accept_elem(nxt);
        elems_in++;
        holding = 1'b0;
      end
      if (!holding) begin
        go = 1'b0;
        if (elem_q.size() > 0) begin
          go = (elems_in >= 150 && elems_in < 230) || ($urandom_range(99) >= 35);
          if (elem_q[0].drain && sorted_q.size() != 0) go = 1'b0;
        end
        if (go) begin
          nxt = elem_q.pop_front();
          s_axis_tdata_i  <= InBits'(nxt.value);
          s_axis_tlast_i  <= nxt.last;
        end
        s_axis_tvalid_i <= go;
      end
    end
  end

  // output side stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) drained++;
      m_axis_tready_i <= (drained >= 120 && drained < 200) || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk_i) begin
    sorted_item_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (sorted_q.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata_o[ValBits-1:0], '0);
      end else begin
        want = sorted_q.pop_front();
        if (m_axis_tdata_o[ValBits-1:0] !== want.value)
          report_mismatch("sorted_value", m_axis_tdata_o[ValBits-1:0], want.value);
        if (m_axis_tdata_o[ValBits +: SwpBits] !== want.swaps)
          report_mismatch("swap_total", ValBits'(m_axis_tdata_o[ValBits +: SwpBits]),
                          ValBits'(want.swaps));
        if (m_axis_tlast_o !== want.last)
          report_mismatch("out_last", ValBits'(m_axis_tlast_o), ValBits'(want.last));
      end
    end
  end

  initial begin
    int n;
    int idx;
    int rand_items;
    logic [ValBits-1:0] base;
    logic [ValBits-1:0] step;

    // single element, no sort
    add_elem(32'h8000_0000, 1'b1, 1'b0);
    // extremes with duplicates
    add_elem(32'h7FFF_FFFF, 1'b0, 1'b0);
    add_elem(32'h8000_0000, 1'b0, 1'b0);
    add_elem(32'h0000_0000, 1'b0, 1'b0);
    add_elem(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_elem(32'h0000_0001, 1'b0, 1'b0);
    add_elem(32'h7FFF_FFFF, 1'b0, 1'b0);
    add_elem(32'h8000_0000, 1'b1, 1'b0);
    // equal values never swap
    add_elem(32'h0005_0000, 1'b0, 1'b0);
    add_elem(32'h0005_0000, 1'b0, 1'b0);
    add_elem(32'h0005_0000, 1'b1, 1'b0);
    // already in order
    add_elem(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_elem(32'h0000_0000, 1'b1, 1'b0);
    // reversed, 4.0 down to -3.0
    for (int k = 0; k < 8; k++)
      add_elem(ValBits'((4 - k) * 65536), k == 7, 1'b0);

    rand_items = 0;
    idx = 0;
    while (rand_items < 255) begin
      if (idx == 2) begin
        // full list strictly descending: most swaps possible
        base = $urandom_range(32'h7FFF_FFFF, 32'h0400_0000);
        step = $urandom_range(32'h0200_0000, 1);
        n = ListDepth;
        for (int k = 0; k < n; k++)
          add_elem(base - ValBits'(k) * step, k == n - 1, k == 0);
      end else if (idx == 7) begin
        // overflow: extra elements are dropped but the last mark still sorts
        n = $urandom_range(ListDepth + 8, ListDepth + 1);
        for (int k = 0; k < n; k++)
          add_elem(rand_elem(), k == n - 1, 1'b0);
      end else begin
        n = $urandom_range(16, 1);
        for (int k = 0; k < n; k++)
          add_elem(rand_elem(), k == n - 1, (idx == 12 && k == 0));
      end
      rand_items += n;
      idx++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (elem_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/css_pkg.sv
rtl/core/cocktail_shaker_sorter_core.sv
verif/cocktail_shaker_sorter_core_tb.sv
